// File: sv/sbe_pkg.sv
// shared types and constants for the stack bytecode executor
`default_nettype none

package sbe_pkg;

    localparam int WORD_W              = 32;
    localparam int ADDR_W              = 16;
    localparam int CMD_W               = 3;
    localparam int FAULT_W             = 2;
    localparam int STACK_DEPTH_DEFAULT = 64;
    localparam int GLOBALS_DEPTH_DEFAULT = 256;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_SUB    = 3'd1,
        CMD_CONST  = 3'd2,
        CMD_BRANCH = 3'd3,
        CMD_GLOAD  = 3'd4,
        CMD_GSTORE = 3'd5,
        CMD_PRINT  = 3'd6,
        CMD_HALT   = 3'd7
    } cmd_t;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_UNDER = 2'd1,
        FAULT_OVER  = 2'd2,
        FAULT_INDEX = 2'd3
    } fault_t;

    typedef struct packed {
        logic   spill_we;
        logic   glob_we;
        logic   print_valid;
        logic   halt_set;
        fault_t fault;
    } exec_ctrl_t;

endpackage

`default_nettype wire

// File: sv/stack_bytecode_executor.sv
// top level: stack and global memories, execute stage and result register
// pipeline: an item moves from the execute stage holding register to the result register,
//   waiting while the result register stalls; s_ready is low until it leaves, so each item
//   reads the stack and global memories when accepted and executes and writes back as it leaves
// reset: after aresetn the global store is swept to zero with s_ready low;
//   the operand stack holds no reset value
`default_nettype none

module stack_bytecode_executor #(
    parameter int STACK_DEPTH   = sbe_pkg::STACK_DEPTH_DEFAULT,
    parameter int GLOBALS_DEPTH = sbe_pkg::GLOBALS_DEPTH_DEFAULT,
    localparam int CNT_W        = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [sbe_pkg::CMD_W-1:0]  s_command,
    input  wire logic [sbe_pkg::WORD_W-1:0] s_operand,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [sbe_pkg::ADDR_W-1:0]      m_next_address,
    output logic                            m_print_valid,
    output logic [sbe_pkg::WORD_W-1:0]      m_print_value,
    output logic                            m_halted,
    output logic [sbe_pkg::FAULT_W-1:0]     m_fault,
    output logic [CNT_W-1:0]                m_stack_depth
);

    localparam int SADDR_W = $clog2(STACK_DEPTH);
    localparam int GIDX_W  = (GLOBALS_DEPTH > 1) ? $clog2(GLOBALS_DEPTH) : 1;

    logic [sbe_pkg::WORD_W-1:0] stack_mem [STACK_DEPTH];
    logic [sbe_pkg::WORD_W-1:0] glob_mem  [GLOBALS_DEPTH];

    logic                       ex_valid_reg;
    sbe_pkg::cmd_t              cmd_reg;
    logic [sbe_pkg::WORD_W-1:0] opnd_reg;
    logic [sbe_pkg::WORD_W-1:0] stack_rd_reg;
    logic [sbe_pkg::WORD_W-1:0] glob_rd_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [sbe_pkg::WORD_W-1:0] top_reg;
    logic [sbe_pkg::ADDR_W-1:0] pc_reg;
    logic                       halt_reg;
    logic                       clearing_reg;
    logic [GIDX_W-1:0]          clr_idx_reg;

    logic                       m_valid_reg;
    logic [sbe_pkg::ADDR_W-1:0] m_next_address_reg;
    logic                       m_print_valid_reg;
    logic [sbe_pkg::WORD_W-1:0] m_print_value_reg;
    logic                       m_halted_reg;
    sbe_pkg::fault_t            m_fault_reg;
    logic [CNT_W-1:0]           m_stack_depth_reg;

    sbe_pkg::exec_ctrl_t        ctrl;
    logic [CNT_W-1:0]           count_next;
    logic [sbe_pkg::WORD_W-1:0] top_next;
    logic [sbe_pkg::ADDR_W-1:0] pc_next;
    logic                       halt_next;

    logic                       s_fire;
    logic                       ex_fire;
    logic [SADDR_W-1:0]         second_addr;
    logic [SADDR_W-1:0]         spill_addr;

    assign s_ready     = !ex_valid_reg && !clearing_reg;
    assign s_fire      = s_valid && s_ready;
    assign ex_fire     = ex_valid_reg && (!m_valid_reg || m_ready);
    assign second_addr = SADDR_W'(count_reg - CNT_W'(2));
    assign spill_addr  = SADDR_W'(count_reg - CNT_W'(1));
    assign halt_next   = halt_reg || ctrl.halt_set;

    sbe_exec #(
        .STACK_DEPTH   (STACK_DEPTH),
        .GLOBALS_DEPTH (GLOBALS_DEPTH)
    ) u_exec (
        .cmd        (cmd_reg),
        .operand    (opnd_reg),
        .count      (count_reg),
        .top        (top_reg),
        .second     (stack_rd_reg),
        .gdata      (glob_rd_reg),
        .pc         (pc_reg),
        .halted     (halt_reg),
        .ctrl       (ctrl),
        .count_next (count_next),
        .top_next   (top_next),
        .pc_next    (pc_next)
    );

    // operand stack below the cached top
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            stack_rd_reg <= stack_mem[second_addr];
        end
        if (ex_fire && ctrl.spill_we) begin
            stack_mem[spill_addr] <= top_reg;
        end
    end

    // global store, swept to zero after reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            glob_rd_reg <= glob_mem[s_operand[GIDX_W-1:0]];
        end
        if (clearing_reg) begin
            glob_mem[clr_idx_reg] <= '0;
        end else if (ex_fire && ctrl.glob_we) begin
            glob_mem[opnd_reg[GIDX_W-1:0]] <= top_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else if (clearing_reg) begin
            if (clr_idx_reg == GIDX_W'(GLOBALS_DEPTH - 1)) begin
                clearing_reg <= 1'b0;
            end
            clr_idx_reg <= clr_idx_reg + GIDX_W'(1);
        end
    end

    // execute stage holding register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
        end else if (s_fire) begin
            ex_valid_reg <= 1'b1;
        end else if (ex_fire) begin
            ex_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg  <= sbe_pkg::cmd_t'(s_command);
            opnd_reg <= s_operand;
        end
    end

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pc_reg    <= '0;
            halt_reg  <= 1'b0;
        end else if (ex_fire) begin
            count_reg <= count_next;
            pc_reg    <= pc_next;
            halt_reg  <= halt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ex_fire) begin
            top_reg <= top_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ex_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ex_fire) begin
            m_next_address_reg <= pc_next;
            m_print_valid_reg  <= ctrl.print_valid;
            m_print_value_reg  <= ctrl.print_valid ? top_reg : '0;
            m_halted_reg       <= halt_next;
            m_fault_reg        <= ctrl.fault;
            m_stack_depth_reg  <= count_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_next_address = m_next_address_reg;
    assign m_print_valid  = m_print_valid_reg;
    assign m_print_value  = m_print_value_reg;
    assign m_halted       = m_halted_reg;
    assign m_fault        = m_fault_reg;
    assign m_stack_depth  = m_stack_depth_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared without reset");

    a_halted_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (ex_fire && halt_reg) |=> ($stable(count_reg) && $stable(pc_reg)))
        else $error("state changed while halted");

    a_fault_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (ex_fire && ctrl.fault != sbe_pkg::FAULT_NONE)
            |=> ($stable(count_reg) && $stable(pc_reg)))
        else $error("faulting item changed state");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (ex_valid_reg && m_valid_reg && !m_ready) |=> ex_valid_reg)
        else $error("execute stage dropped an item under output stall");

endmodule

`default_nettype wire

// File: sv/sbe_exec.sv
// execute logic: decodes one instruction against the cached top and read data
`default_nettype none

module sbe_exec #(
    parameter int STACK_DEPTH   = sbe_pkg::STACK_DEPTH_DEFAULT,
    parameter int GLOBALS_DEPTH = sbe_pkg::GLOBALS_DEPTH_DEFAULT,
    localparam int CNT_W        = $clog2(STACK_DEPTH + 1)
) (
    input  wire sbe_pkg::cmd_t              cmd,
    input  wire logic [sbe_pkg::WORD_W-1:0] operand,
    input  wire logic [CNT_W-1:0]           count,
    input  wire logic [sbe_pkg::WORD_W-1:0] top,
    input  wire logic [sbe_pkg::WORD_W-1:0] second,
    input  wire logic [sbe_pkg::WORD_W-1:0] gdata,
    input  wire logic [sbe_pkg::ADDR_W-1:0] pc,
    input  wire logic                       halted,
    output sbe_pkg::exec_ctrl_t             ctrl,
    output logic [CNT_W-1:0]                count_next,
    output logic [sbe_pkg::WORD_W-1:0]      top_next,
    output logic [sbe_pkg::ADDR_W-1:0]      pc_next
);

    logic                       idx_ok;
    logic                       stack_empty;
    logic                       stack_short;
    logic                       stack_full;
    logic [sbe_pkg::ADDR_W-1:0] pc_inc1;
    logic [sbe_pkg::ADDR_W-1:0] pc_inc2;

    assign idx_ok      = operand < sbe_pkg::WORD_W'(GLOBALS_DEPTH);
    assign stack_empty = count == '0;
    assign stack_short = count < CNT_W'(2);
    assign stack_full  = count >= CNT_W'(STACK_DEPTH);
    assign pc_inc1     = pc + sbe_pkg::ADDR_W'(1);
    assign pc_inc2     = pc + sbe_pkg::ADDR_W'(2);

    always_comb begin
        ctrl       = '0;
        ctrl.fault = sbe_pkg::FAULT_NONE;
        count_next = count;
        top_next   = top;
        pc_next    = pc;
        if (!halted) begin
            case (cmd)
                sbe_pkg::CMD_ADD, sbe_pkg::CMD_SUB: begin
                    if (stack_short) begin
                        ctrl.fault = sbe_pkg::FAULT_UNDER;
                    end else begin
                        top_next   = (cmd == sbe_pkg::CMD_ADD) ? second + top : second - top;
                        count_next = count - CNT_W'(1);
                        pc_next    = pc_inc1;
                    end
                end
                sbe_pkg::CMD_CONST: begin
                    if (stack_full) begin
                        ctrl.fault = sbe_pkg::FAULT_OVER;
                    end else begin
                        ctrl.spill_we = !stack_empty;
                        top_next      = operand;
                        count_next    = count + CNT_W'(1);
                        pc_next       = pc_inc2;
                    end
                end
                sbe_pkg::CMD_BRANCH: begin
                    if (stack_empty) begin
                        ctrl.fault = sbe_pkg::FAULT_UNDER;
                    end else begin
                        pc_next = (top != '0) ? operand[sbe_pkg::ADDR_W-1:0] : pc_inc2;
                    end
                end
                sbe_pkg::CMD_GLOAD: begin
                    if (stack_full) begin
                        ctrl.fault = sbe_pkg::FAULT_OVER;
                    end else if (!idx_ok) begin
                        ctrl.fault = sbe_pkg::FAULT_INDEX;
                    end else begin
                        ctrl.spill_we = !stack_empty;
                        top_next      = gdata;
                        count_next    = count + CNT_W'(1);
                        pc_next       = pc_inc2;
                    end
                end
                sbe_pkg::CMD_GSTORE: begin
                    if (stack_empty) begin
                        ctrl.fault = sbe_pkg::FAULT_UNDER;
                    end else if (!idx_ok) begin
                        ctrl.fault = sbe_pkg::FAULT_INDEX;
                    end else begin
                        ctrl.glob_we = 1'b1;
                        top_next     = second;
                        count_next   = count - CNT_W'(1);
                        pc_next      = pc_inc2;
                    end
                end
                sbe_pkg::CMD_PRINT: begin
                    if (stack_empty) begin
                        ctrl.fault = sbe_pkg::FAULT_UNDER;
                    end else begin
                        ctrl.print_valid = 1'b1;
                        pc_next          = pc_inc1;
                    end
                end
                default: begin
                    ctrl.halt_set = 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sim/stack_bytecode_executor_checker.sv
`timescale 1ns / 100ps
// stack_bytecode_executor_checker.sv: instruction predictor and result comparison for the executor

module stack_bytecode_executor_checker #(
    parameter int DEPTH_W = 7
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    input  wire logic                         s_ready,
    input  wire logic [sbe_pkg::CMD_W-1:0]    s_command,
    input  wire logic [sbe_pkg::WORD_W-1:0]   s_operand,
    input  wire logic                         m_valid,
    input  wire logic                         m_ready,
    input  wire logic [sbe_pkg::ADDR_W-1:0]   m_next_address,
    input  wire logic                         m_print_valid,
    input  wire logic [sbe_pkg::WORD_W-1:0]   m_print_value,
    input  wire logic                         m_halted,
    input  wire logic [sbe_pkg::FAULT_W-1:0]  m_fault,
    input  wire logic [DEPTH_W-1:0]           m_stack_depth,
    output int                                mismatch_total,
    output int                                outcomes_due
);

    typedef struct packed {
        logic [sbe_pkg::ADDR_W-1:0] next_address;
        logic                       print_valid;
        logic [sbe_pkg::WORD_W-1:0] print_value;
        logic                       halted;
        sbe_pkg::fault_t            fault;
        logic [DEPTH_W-1:0]         stack_depth;
    } step_outcome_t;

    logic [sbe_pkg::WORD_W-1:0] stack_words  [sbe_pkg::STACK_DEPTH_DEFAULT];
    logic [sbe_pkg::WORD_W-1:0] global_words [sbe_pkg::GLOBALS_DEPTH_DEFAULT];
    int unsigned                depth_now;
    logic [sbe_pkg::ADDR_W-1:0] pc_now;
    logic                       halted_now;
    step_outcome_t              outcome_q [$];

    function automatic step_outcome_t execute(sbe_pkg::cmd_t cmd,
                                              logic [sbe_pkg::WORD_W-1:0] opnd);
        step_outcome_t              r;
        logic [sbe_pkg::WORD_W-1:0] top_w;
        logic [sbe_pkg::WORD_W-1:0] below_w;
        logic [sbe_pkg::ADDR_W-1:0] next_pc;
        r = '0;
        next_pc = pc_now;
        if (!halted_now) begin
            case (cmd)
                sbe_pkg::CMD_ADD, sbe_pkg::CMD_SUB: begin
                    if (depth_now < 2) begin
                        r.fault = sbe_pkg::FAULT_UNDER;
                    end else begin
                        top_w = stack_words[depth_now - 1];
                        below_w = stack_words[depth_now - 2];
                        stack_words[depth_now - 2] = (cmd == sbe_pkg::CMD_ADD) ? below_w + top_w
                                                                               : below_w - top_w;
                        depth_now = depth_now - 1;
                        next_pc = pc_now + sbe_pkg::ADDR_W'(1);
                    end
                end
                sbe_pkg::CMD_CONST: begin
                    if (depth_now >= sbe_pkg::STACK_DEPTH_DEFAULT) begin
                        r.fault = sbe_pkg::FAULT_OVER;
                    end else begin
                        stack_words[depth_now] = opnd;
                        depth_now = depth_now + 1;
                        next_pc = pc_now + sbe_pkg::ADDR_W'(2);
                    end
                end
                sbe_pkg::CMD_BRANCH: begin
                    if (depth_now < 1) begin
                        r.fault = sbe_pkg::FAULT_UNDER;
                    end else if (stack_words[depth_now - 1] != 0) begin
                        next_pc = opnd[sbe_pkg::ADDR_W-1:0];
                    end else begin
                        next_pc = pc_now + sbe_pkg::ADDR_W'(2);
                    end
                end
                sbe_pkg::CMD_GLOAD: begin
                    if (depth_now >= sbe_pkg::STACK_DEPTH_DEFAULT) begin
                        r.fault = sbe_pkg::FAULT_OVER;
                    end else if (opnd >= sbe_pkg::GLOBALS_DEPTH_DEFAULT) begin
                        r.fault = sbe_pkg::FAULT_INDEX;
                    end else begin
                        stack_words[depth_now] = global_words[opnd];
                        depth_now = depth_now + 1;
                        next_pc = pc_now + sbe_pkg::ADDR_W'(2);
                    end
                end
                sbe_pkg::CMD_GSTORE: begin
                    if (depth_now < 1) begin
                        r.fault = sbe_pkg::FAULT_UNDER;
                    end else if (opnd >= sbe_pkg::GLOBALS_DEPTH_DEFAULT) begin
                        r.fault = sbe_pkg::FAULT_INDEX;
                    end else begin
                        global_words[opnd] = stack_words[depth_now - 1];
                        depth_now = depth_now - 1;
                        next_pc = pc_now + sbe_pkg::ADDR_W'(2);
                    end
                end
                sbe_pkg::CMD_PRINT: begin
                    if (depth_now < 1) begin
                        r.fault = sbe_pkg::FAULT_UNDER;
                    end else begin
                        r.print_valid = 1'b1;
                        r.print_value = stack_words[depth_now - 1];
                        next_pc = pc_now + sbe_pkg::ADDR_W'(1);
                    end
                end
                default: begin
                    halted_now = 1'b1;
                end
            endcase
            pc_now = next_pc;
        end
        r.next_address = pc_now;
        r.halted = halted_now;
        r.stack_depth = depth_now[DEPTH_W-1:0];
        return r;
    endfunction

    task automatic check_field(string what, logic [sbe_pkg::WORD_W-1:0] want,
                               logic [sbe_pkg::WORD_W-1:0] got);
        if (want !== got) begin
            mismatch_total++;
            $display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        step_outcome_t want;
        if (!aresetn) begin
            foreach (global_words[i]) global_words[i] = '0;
            foreach (stack_words[i]) stack_words[i] = '0;
            depth_now = 0;
            pc_now = '0;
            halted_now = 1'b0;
            outcome_q.delete();
            mismatch_total = 0;
            outcomes_due <= 0;
        end else begin
            if (s_valid && s_ready) begin
                outcome_q.push_back(execute(sbe_pkg::cmd_t'(s_command), s_operand));
            end
            if (m_valid && m_ready) begin
                if (outcome_q.size() == 0) begin
                    mismatch_total++;
                    $display("%0t unexpected result: expected none actual next_address %0h",
                             $time, m_next_address);
                end else begin
                    want = outcome_q.pop_front();
                    check_field("next_address", sbe_pkg::WORD_W'(want.next_address),
                                sbe_pkg::WORD_W'(m_next_address));
                    check_field("print_valid", sbe_pkg::WORD_W'(want.print_valid),
                                sbe_pkg::WORD_W'(m_print_valid));
                    check_field("print_value", want.print_value, m_print_value);
                    check_field("halted", sbe_pkg::WORD_W'(want.halted),
                                sbe_pkg::WORD_W'(m_halted));
                    check_field("fault", sbe_pkg::WORD_W'(want.fault),
                                sbe_pkg::WORD_W'(m_fault));
                    check_field("stack_depth", sbe_pkg::WORD_W'(want.stack_depth),
                                sbe_pkg::WORD_W'(m_stack_depth));
                end
            end
            outcomes_due <= outcome_q.size();
        end
    end

endmodule

// File: sim/stack_bytecode_executor_tb.sv
`timescale 1ns / 100ps
// stack_bytecode_executor_tb.sv: clock, reset, instruction stimulus and verdict for the executor

module stack_bytecode_executor_tb;

    localparam int DEPTH_W      = $clog2(sbe_pkg::STACK_DEPTH_DEFAULT + 1);
    localparam int RANDOM_ITEMS = 500;
    localparam int IDLE_LIMIT   = 5000;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [sbe_pkg::CMD_W-1:0]     s_command = '0;
    logic [sbe_pkg::WORD_W-1:0]    s_operand = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [sbe_pkg::ADDR_W-1:0]    m_next_address;
    logic                          m_print_valid;
    logic [sbe_pkg::WORD_W-1:0]    m_print_value;
    logic                          m_halted;
    logic [sbe_pkg::FAULT_W-1:0]   m_fault;
    logic [DEPTH_W-1:0]            m_stack_depth;

    int          fail_count;
    int          outcomes_due;
    int unsigned idle_cycles = 0;
    int unsigned ready_hold = 0;
    int unsigned ready_free = 0;
    int unsigned send_free = 0;
    int unsigned stim_depth = 0;
    int unsigned items_sent = 0;
    int unsigned fills_done = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    stack_bytecode_executor dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_operand      (s_operand),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_next_address (m_next_address),
        .m_print_valid  (m_print_valid),
        .m_print_value  (m_print_value),
        .m_halted       (m_halted),
        .m_fault        (m_fault),
        .m_stack_depth  (m_stack_depth)
    );

    stack_bytecode_executor_checker #(
        .DEPTH_W (DEPTH_W)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_operand      (s_operand),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_next_address (m_next_address),
        .m_print_valid  (m_print_valid),
        .m_print_value  (m_print_value),
        .m_halted       (m_halted),
        .m_fault        (m_fault),
        .m_stack_depth  (m_stack_depth),
        .mismatch_total (fail_count),
        .outcomes_due   (outcomes_due)
    );

    function automatic int unsigned gap_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [sbe_pkg::WORD_W-1:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom;
        if (r < 75) return $urandom_range(0, 15);
        if (r < 85) return '1;
        if (r < 92) return {1'b1, {(sbe_pkg::WORD_W-1){1'b0}}};
        return '0;
    endfunction

    function automatic logic [sbe_pkg::WORD_W-1:0] pick_index();
        if ($urandom_range(0, 99) < 80) begin
            return $urandom_range(0, sbe_pkg::GLOBALS_DEPTH_DEFAULT - 1);
        end
        if ($urandom_range(0, 1) == 0) return sbe_pkg::GLOBALS_DEPTH_DEFAULT;
        return $urandom;
    endfunction

    // result side back-pressure
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            m_ready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready <= 1'b1;
            if (ready_free != 0) begin
                ready_free <= ready_free - 1;
            end else if ($urandom_range(0, 99) < 4) begin
                ready_free <= $urandom_range(20, 100);
            end else if ($urandom_range(0, 99) < 30) begin
                ready_hold <= gap_cycles();
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("stack_bytecode_executor regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(sbe_pkg::cmd_t cmd, logic [sbe_pkg::WORD_W-1:0] opnd);
        int unsigned gap;
        if (send_free != 0) begin
            send_free--;
            gap = 0;
        end else if ($urandom_range(0, 99) < 4) begin
            send_free = $urandom_range(10, 60);
            gap = 0;
        end else begin
            gap = gap_cycles();
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_operand <= opnd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        // rough depth tracking, only to shape the stimulus
        case (cmd)
            sbe_pkg::CMD_ADD, sbe_pkg::CMD_SUB: if (stim_depth >= 2) stim_depth--;
            sbe_pkg::CMD_CONST: if (stim_depth < sbe_pkg::STACK_DEPTH_DEFAULT) stim_depth++;
            sbe_pkg::CMD_GLOAD: begin
                if (stim_depth < sbe_pkg::STACK_DEPTH_DEFAULT
                        && opnd < sbe_pkg::GLOBALS_DEPTH_DEFAULT) stim_depth++;
            end
            sbe_pkg::CMD_GSTORE: begin
                if (stim_depth >= 1 && opnd < sbe_pkg::GLOBALS_DEPTH_DEFAULT) stim_depth--;
            end
            default: ;
        endcase
    endtask

    // push to a full stack, overflow it, then drain back down
    task automatic fill_stack();
        while (stim_depth < sbe_pkg::STACK_DEPTH_DEFAULT) begin
            if ($urandom_range(0, 3) == 0) send_item(sbe_pkg::CMD_GLOAD, $urandom_range(0, 255));
            else send_item(sbe_pkg::CMD_CONST, pick_word());
        end
        send_item(sbe_pkg::CMD_GLOAD,
                  $urandom_range(sbe_pkg::GLOBALS_DEPTH_DEFAULT, 32'hffff_ffff));
        send_item(sbe_pkg::CMD_CONST, pick_word());
        send_item(sbe_pkg::CMD_PRINT, $urandom);
        send_item(sbe_pkg::CMD_GLOAD, $urandom_range(0, sbe_pkg::GLOBALS_DEPTH_DEFAULT - 1));
        while (stim_depth > 2) begin
            case ($urandom_range(0, 2))
                0: send_item(sbe_pkg::CMD_ADD, $urandom);
                1: send_item(sbe_pkg::CMD_SUB, $urandom);
                default: begin
                    send_item(sbe_pkg::CMD_GSTORE,
                              $urandom_range(0, sbe_pkg::GLOBALS_DEPTH_DEFAULT - 1));
                end
            endcase
        end
        fills_done++;
    endtask

    task automatic random_item();
        int unsigned push_w;
        int unsigned r;
        push_w = (stim_depth < 4) ? 50 : ((stim_depth > 12) ? 15 : 30);
        if ($urandom_range(0, 99) < push_w) begin
            if ($urandom_range(0, 2) == 0) send_item(sbe_pkg::CMD_GLOAD, pick_index());
            else send_item(sbe_pkg::CMD_CONST, pick_word());
        end else begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                send_item($urandom_range(0, 1) ? sbe_pkg::CMD_ADD : sbe_pkg::CMD_SUB, $urandom);
            end else if (r < 50) begin
                send_item(sbe_pkg::CMD_GSTORE, pick_index());
            end else if (r < 65) begin
                send_item(sbe_pkg::CMD_PRINT, $urandom);
            end else if (r < 80) begin
                send_item(sbe_pkg::CMD_BRANCH, $urandom);
            end else if (r < 98 || fills_done >= 3) begin
                send_item(sbe_pkg::cmd_t'($urandom_range(0, 6)), $urandom);
            end else begin
                fill_stack();
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // underflow on an empty stack, gstore stack check ahead of index check
        send_item(sbe_pkg::CMD_PRINT, '0);
        send_item(sbe_pkg::CMD_ADD, '0);
        send_item(sbe_pkg::CMD_SUB, '0);
        send_item(sbe_pkg::CMD_BRANCH, 32'h0000_0040);
        send_item(sbe_pkg::CMD_GSTORE, sbe_pkg::GLOBALS_DEPTH_DEFAULT);
        send_item(sbe_pkg::CMD_GLOAD, sbe_pkg::GLOBALS_DEPTH_DEFAULT - 1);
        send_item(sbe_pkg::CMD_SUB, '0);
        // wraparound arithmetic
        send_item(sbe_pkg::CMD_CONST, 32'hffff_ffff);
        send_item(sbe_pkg::CMD_ADD, '0);
        send_item(sbe_pkg::CMD_CONST, 32'h0000_0001);
        send_item(sbe_pkg::CMD_ADD, '0);
        send_item(sbe_pkg::CMD_BRANCH, 32'h0000_1234);
        send_item(sbe_pkg::CMD_PRINT, '0);
        send_item(sbe_pkg::CMD_CONST, 32'h0000_0001);
        send_item(sbe_pkg::CMD_SUB, '0);
        // branch to the top address, then pc wraps
        send_item(sbe_pkg::CMD_BRANCH, 32'hffff_ffff);
        send_item(sbe_pkg::CMD_CONST, 32'h8000_0000);
        send_item(sbe_pkg::CMD_GSTORE, sbe_pkg::GLOBALS_DEPTH_DEFAULT - 1);
        send_item(sbe_pkg::CMD_GLOAD, sbe_pkg::GLOBALS_DEPTH_DEFAULT - 1);
        send_item(sbe_pkg::CMD_CONST, 32'h7fff_ffff);
        send_item(sbe_pkg::CMD_ADD, '0);
        send_item(sbe_pkg::CMD_GSTORE, sbe_pkg::GLOBALS_DEPTH_DEFAULT);
        send_item(sbe_pkg::CMD_GLOAD, 32'hffff_ffff);
        send_item(sbe_pkg::CMD_PRINT, '0);
        send_item(sbe_pkg::CMD_GSTORE, '0);
        send_item(sbe_pkg::CMD_GLOAD, '0);

        fill_stack();
        while (items_sent < RANDOM_ITEMS + 26) random_item();

        // halt, then items that must be ignored
        send_item(sbe_pkg::CMD_HALT, $urandom);
        send_item(sbe_pkg::CMD_CONST, $urandom);
        send_item(sbe_pkg::CMD_PRINT, '0);
        send_item(sbe_pkg::CMD_HALT, '0);
        send_item(sbe_pkg::CMD_GLOAD, '0);
        s_valid <= 1'b0;

        @(posedge aclk);
        while (outcomes_due != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("stack_bytecode_executor regression: pass");
        end else begin
            $display("stack_bytecode_executor regression: fail");
        end
        $finish;
    end

endmodule
